### src/dtbl_pkg.sv
package dtbl_pkg;

	localparam int unsigned SlotCount = 256;
	localparam int unsigned SlotIdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
	localparam int unsigned SlotW = 32 + 16 + 48;
	localparam logic [31:0] HashMult = 32'd2654435761;

	localparam logic [1:0] RegGlobalBurst = 2'd0;
	localparam logic [1:0] RegGlobalPeriod = 2'd1;
	localparam logic [1:0] RegSlotBurst = 2'd2;
	localparam logic [1:0] RegSlotPeriod = 2'd3;

	typedef struct packed {
		logic clr_start;
		logic clr_step;
		logic load;
		logic hash;
		logic fetch;
		logic div_start;
		logic div_sel;
		logic div_step;
		logic div_take;
		logic decide;
		logic commit;
		logic restart;
		logic emit;
	} dtbl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic is_restart;
	} dtbl_sts_t;

endpackage

### src/dtbl_ram.sv
module dtbl_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                            wdata,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                            rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### src/dtbl_ctrl.sv
module dtbl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output dtbl_pkg::dtbl_cmd_t cmd,
	input  dtbl_pkg::dtbl_sts_t sts
);
	import dtbl_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_HASH, ST_FETCH, ST_GDIV, ST_SDIV_START, ST_SDIV,
		ST_DECIDE, ST_COMMIT, ST_RESTART, ST_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load = accept;
		case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_HASH: cmd.hash = 1'b1;
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				cmd.div_start = 1'b1;
			end
			ST_GDIV: begin
				cmd.div_step = !sts.div_done;
				cmd.div_take = sts.div_done;
			end
			ST_SDIV_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = 1'b1;
			end
			ST_SDIV: begin
				cmd.div_sel = 1'b1;
				cmd.div_step = !sts.div_done;
				cmd.div_take = sts.div_done;
			end
			ST_DECIDE: cmd.decide = 1'b1;
			ST_COMMIT: cmd.commit = 1'b1;
			ST_RESTART: begin
				cmd.restart = 1'b1;
				cmd.clr_start = 1'b1;
			end
			ST_OUT: cmd.emit = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: if (sts.clr_last) begin
					state_q <= ST_IDLE;
				end
				ST_IDLE: if (accept) begin
					state_q <= ST_HASH;
				end
				ST_HASH: state_q <= sts.is_restart ? ST_RESTART : ST_FETCH;
				ST_FETCH: state_q <= ST_GDIV;
				ST_GDIV: if (sts.div_done) begin
					state_q <= ST_SDIV_START;
				end
				ST_SDIV_START: state_q <= ST_SDIV;
				ST_SDIV: if (sts.div_done) begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: state_q <= ST_COMMIT;
				ST_COMMIT: state_q <= ST_OUT;
				ST_RESTART: state_q <= ST_OUT;
				ST_OUT: if (!out_valid_q || !out_stall) begin
					out_valid_q <= 1'b1;
					state_q     <= sts.is_restart ? ST_CLEAR : ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("accept outside idle");
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result raised outside output state");
	a_div_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.div_step && cmd.div_take))
		else $error("divider step and take together");
`endif
endmodule

### src/dtbl_dp.sv
module dtbl_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               command,
	input  logic [31:0]        addr,
	input  logic [47:0]        now_ms,
	output logic               allowed,
	input  dtbl_pkg::dtbl_cmd_t cmd,
	output dtbl_pkg::dtbl_sts_t sts
);
	import dtbl_pkg::*;

	logic [9:0]  gburst_q, sburst_q;
	logic [15:0] gper_q, sper_q;
	logic [15:0] glevel_q;
	logic [47:0] gstamp_q;
	logic        cmd_q;
	logic [31:0] addr_q;
	logic [47:0] now_q;
	logic [SlotIdxW-1:0] idx_q, clr_q;
	logic        clr_last_q;
	logic        ok_q;
	logic        allowed_q;
	logic [SlotW-1:0] rd, wdata;
	logic        we;
	logic [SlotIdxW-1:0] waddr, raddr;
	logic [31:0] hash;
	logic [31:0] s_addr;
	logic [15:0] s_tok;
	logic [47:0] s_last;
	logic [47:0] s_last_q;
	logic [15:0] s_tok_q;
	logic        smatch_q;
	logic [15:0] rem_q;
	logic [53:0] quo_q;
	logic [5:0]  cnt_q;
	logic [15:0] div_per;
	logic [16:0] diff;
	logic [47:0] span;
	logic [47:0] prev;
	logic [15:0] gfill_q, sfill_q;
	logic [15:0] gcap, scap;
	logic [16:0] sum;
	logic [15:0] fill;
	logic [15:0] gnew_q, snew_q;
	logic [53:0] q;
	logic [15:0] lvl;
	logic [15:0] cap;
	logic [15:0] per;

	assign hash   = addr_q * HashMult;
	assign s_addr = rd[SlotW-1 -: 32];
	assign s_tok  = rd[63:48];
	assign s_last = rd[47:0];
	assign gcap   = {gburst_q, 6'd0};
	assign scap   = {sburst_q, 6'd0};
	assign div_per = cmd.div_sel ? sper_q : gper_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gburst_q <= 10'd32;
			gper_q   <= 16'd50;
			sburst_q <= 10'd4;
			sper_q   <= 16'd500;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegGlobalBurst: gburst_q <= cfg_data[9:0];
				RegGlobalPeriod: gper_q <= cfg_data;
				RegSlotBurst: sburst_q <= cfg_data[9:0];
				RegSlotPeriod: sper_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// restoring divider: rem_q holds the partial remainder, quo_q shifts
	// dividend bits out at the top and quotient bits in at the bottom
	assign prev = cmd.div_sel ? s_last_q : gstamp_q;
	assign span = (now_q > prev) ? now_q - prev : 48'd0;
	assign diff = {rem_q, quo_q[53]} - {1'b0, div_per};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glevel_q   <= 16'd2048;
			gstamp_q   <= '0;
			clr_q      <= '0;
			clr_last_q <= 1'b0;
			ok_q       <= 1'b0;
			allowed_q  <= 1'b0;
			cnt_q      <= '0;
		end else begin
			clr_last_q <= 1'b0;
			if (cmd.clr_start) begin
				clr_q <= '0;
			end else if (cmd.clr_step) begin
				clr_q      <= clr_q + 1'b1;
				clr_last_q <= (clr_q == SlotIdxW'(SlotCount - 1));
			end
			if (cmd.restart) begin
				glevel_q <= gcap;
				gstamp_q <= now_q;
				ok_q     <= 1'b0;
			end
			if (cmd.div_start) begin
				cnt_q <= 6'd54;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.decide) begin
				ok_q <= (gfill_q >= 16'd64) && (sfill_q >= 16'd64);
			end
			if (cmd.commit) begin
				glevel_q <= gnew_q;
				gstamp_q <= now_q;
			end
			if (cmd.emit) begin
				allowed_q <= ok_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= command;
			addr_q <= addr;
			now_q  <= now_ms;
		end
		if (cmd.hash) begin
			idx_q <= hash[SlotIdxW-1:0];
		end
		if (cmd.fetch) begin
			s_tok_q  <= s_tok;
			s_last_q <= s_last;
			smatch_q <= (s_addr == addr_q);
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= {span, 6'd0};
		end else if (cmd.div_step) begin
			if (!diff[16]) begin
				rem_q <= diff[15:0];
				quo_q <= {quo_q[52:0], 1'b1};
			end else begin
				rem_q <= {rem_q[14:0], quo_q[53]};
				quo_q <= {quo_q[52:0], 1'b0};
			end
		end
		if (cmd.div_take) begin
			if (cmd.div_sel) begin
				sfill_q <= fill;
			end else begin
				gfill_q <= fill;
			end
		end
		if (cmd.decide) begin
			if (gfill_q >= 16'd64 && sfill_q >= 16'd64) begin
				gnew_q <= gfill_q - 16'd64;
				snew_q <= sfill_q - 16'd64;
			end else begin
				gnew_q <= gfill_q;
				snew_q <= sfill_q;
			end
		end
	end

	assign q   = quo_q;
	assign lvl = cmd.div_sel ? s_tok_q : glevel_q;
	assign cap = cmd.div_sel ? scap : gcap;
	assign per = div_per;
	assign sum = {1'b0, lvl} + ((|q[53:16]) ? 17'h10000 : {1'b0, q[15:0]});
	always_comb begin
		if (per == 16'd0 || (cmd.div_sel && !smatch_q)) begin
			fill = cap;
		end else if (sum > {1'b0, cap}) begin
			fill = cap;
		end else begin
			fill = sum[15:0];
		end
	end

	assign we    = cmd.commit || cmd.clr_step;
	assign waddr = cmd.clr_step ? clr_q : idx_q;
	assign wdata = cmd.clr_step ? '0 : {addr_q, snew_q, now_q};
	assign raddr = cmd.hash ? hash[SlotIdxW-1:0] : idx_q;

	dtbl_ram #(.Width(SlotW), .Depth(SlotCount)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rd)
	);

	assign allowed = allowed_q;
	assign sts.clr_last = clr_last_q;
	assign sts.div_done = (cnt_q == 6'd0);
	assign sts.is_restart = cmd_q;

`ifndef NO_ASSERTIONS
	a_cap_g: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.commit) |-> (glevel_q <= gcap || $past(cfg_valid)))
		else $error("global level over cap");
	a_clr_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		clr_last_q |-> (clr_q == '0))
		else $error("clear sweep end misplaced");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.div_start) |-> (cnt_q == 6'd54))
		else $error("divider count not loaded");
`endif
endmodule

### src/dual_token_bucket_limiter.sv
// Admission limiter: one beat in, one beat out. A check passes through hash,
// fetch, two 54-step restoring divisions (global and per-address refill) that
// share one divider, decide and commit before its result is raised; the next
// beat can be taken in the same cycle that the result is raised. A result that
// is still stalled holds the next one back in the output state. A restart
// raises its result after the hash and restart states and is followed by a
// sweep that clears the slot table; the same sweep runs after reset. No input
// is taken during either.
module dual_token_bucket_limiter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [31:0] addr,
	input  logic [47:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        allowed
);
	import dtbl_pkg::*;

	dtbl_cmd_t cmd;
	dtbl_sts_t sts;

	assign cfg_ready = 1'b1;

	dtbl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
	);

	dtbl_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .command(command), .addr(addr), .now_ms(now_ms),
		.allowed(allowed), .cmd(cmd), .sts(sts)
	);
endmodule

### bench/dual_token_bucket_limiter_tb.sv
module dual_token_bucket_limiter_tb;
	import dtbl_pkg::*;

	typedef struct packed {
		logic        cmd;
		logic [31:0] a;
		logic [47:0] t;
		logic        known;
		logic        res;
	} dir_beat_t;

	localparam int DirCount = 15;
	localparam int PhaseCount = 7;
	localparam int PhaseBeats = 290;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        command;
	logic [31:0] addr;
	logic [47:0] now_ms;
	logic        out_valid;
	logic        out_stall;
	logic        allowed;

	logic [9:0]  gbl_burst, slt_burst;
	logic [15:0] gbl_period, slt_period;
	logic [15:0] gbl_level;
	logic [47:0] gbl_stamp;
	logic [31:0] slt_addr [SlotCount];
	logic [15:0] slt_tokens [SlotCount];
	logic [47:0] slt_last [SlotCount];

	logic        verdicts_due [$];
	int          mismatches;
	bit          quiet;
	int          stall_left;
	logic [31:0] addr_pool [16];
	logic [47:0] clock_ms;

	dir_beat_t dir_tab [DirCount] = '{
		'{1'b0, 32'h0000_0000, 48'd0, 1'b1, 1'b0},
		'{1'b0, 32'h0000_0000, 48'd1000, 1'b0, 1'b0},
		'{1'b0, 32'h0000_0000, 48'd5, 1'b0, 1'b0},
		'{1'b0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0},
		'{1'b1, 32'hFFFF_FFFF, 48'd100, 1'b1, 1'b0},
		'{1'b0, 32'h1234_5678, 48'd100, 1'b1, 1'b1},
		'{1'b0, 32'h1234_5678, 48'd100, 1'b1, 1'b1},
		'{1'b0, 32'h1234_5678, 48'd100, 1'b1, 1'b1},
		'{1'b0, 32'h1234_5678, 48'd100, 1'b1, 1'b1},
		'{1'b0, 32'h1234_5678, 48'd100, 1'b1, 1'b0},
		'{1'b0, 32'h1234_5678, 48'd600, 1'b0, 1'b0},
		'{1'b0, 32'h8000_0000, 48'h8000_0000_0000, 1'b0, 1'b0},
		'{1'b0, 32'h0000_0001, 48'h7FFF_FFFF_FFFF, 1'b0, 1'b0},
		'{1'b0, 32'h5555_5555, 48'h5555_5555_5555, 1'b0, 1'b0},
		'{1'b0, 32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA, 1'b0, 1'b0}
	};

	dual_token_bucket_limiter u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .addr(addr), .now_ms(now_ms),
		.out_valid(out_valid), .out_stall(out_stall), .allowed(allowed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("dual_token_bucket_limiter_tb: done, errors");
		$finish;
	end

	function automatic logic [15:0] refilled(logic [15:0] lvl, logic [47:0] prev,
			logic [47:0] now, logic [15:0] period, logic [9:0] burst);
		logic [63:0] cap, span, total;
		cap = 64'(burst) * 64;
		if (period == 0)
			return cap[15:0];
		span = (now > prev) ? 64'(now - prev) : 64'd0;
		total = 64'(lvl) + (span * 64) / 64'(period);
		return (total > cap) ? cap[15:0] : total[15:0];
	endfunction

	function automatic int slot_of(logic [31:0] a);
		logic [63:0] prod;
		prod = 64'(a) * 64'(HashMult);
		return int'(prod[31:0] % SlotCount);
	endfunction

	function automatic void clear_table();
		for (int i = 0; i < SlotCount; i++) begin
			slt_addr[i] = '0;
			slt_tokens[i] = '0;
			slt_last[i] = '0;
		end
	endfunction

	function automatic logic admit(logic cmd, logic [31:0] a, logic [47:0] t);
		logic [15:0] g, s;
		int i;
		logic ok;
		if (cmd) begin
			gbl_level = 16'(32'(gbl_burst) * 64);
			gbl_stamp = t;
			clear_table();
			return 1'b0;
		end
		g = refilled(gbl_level, gbl_stamp, t, gbl_period, gbl_burst);
		i = slot_of(a);
		if (slt_addr[i] == a)
			s = refilled(slt_tokens[i], slt_last[i], t, slt_period, slt_burst);
		else
			s = 16'(32'(slt_burst) * 64);
		ok = (g >= 64) && (s >= 64);
		if (ok) begin
			g = g - 16'd64;
			s = s - 16'd64;
		end
		gbl_level = g;
		gbl_stamp = t;
		slt_addr[i] = a;
		slt_tokens[i] = s;
		slt_last[i] = t;
		return ok;
	endfunction

	task automatic send_beat(logic cmd, logic [31:0] a, logic [47:0] t, bit known, logic res);
		logic predicted;
		in_valid <= 1'b1;
		command <= cmd;
		addr <= a;
		now_ms <= t;
		do @(posedge clk); while (in_stall !== 1'b0);
		predicted = admit(cmd, a, t);
		verdicts_due.push_back(known ? res : predicted);
	endtask

	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic drain(int settle);
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		case (idx)
			RegGlobalBurst:  gbl_burst = data[9:0];
			RegGlobalPeriod: gbl_period = data;
			RegSlotBurst:    slt_burst = data[9:0];
			RegSlotPeriod:   slt_period = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic random_beat();
		int pick;
		logic [31:0] a;
		pick = $urandom_range(0, 99);
		a = (pick < 85) ? addr_pool[$urandom_range(0, 15)] : $urandom;
		if (pick < 2) begin
			send_beat(1'b1, a, clock_ms, 1'b0, 1'b0);
			return;
		end
		if (pick < 5)
			clock_ms = clock_ms - 48'($urandom_range(1, 2000));
		else if (pick < 7)
			clock_ms = 48'({$urandom, $urandom});
		else
			clock_ms = clock_ms + 48'($urandom_range(0, (pick < 60) ? 120 : 1500));
		send_beat(1'b0, a, clock_ms, 1'b0, 1'b0);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (verdicts_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: allowed=%0b", allowed);
			end else begin
				logic want;
				want = verdicts_due.pop_front();
				if (allowed !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("allowed mismatch: expected %0b, got %0b", want, allowed);
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 8) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		logic [15:0] cfg_set [PhaseCount][4];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = RegGlobalBurst;
		cfg_data = '0;
		in_valid = 1'b0;
		command = 1'b0;
		addr = '0;
		now_ms = '0;
		out_stall = 1'b0;
		mismatches = 0;
		quiet = 1'b0;
		stall_left = 0;
		gbl_burst = 10'd32;
		gbl_period = 16'd50;
		slt_burst = 10'd4;
		slt_period = 16'd500;
		gbl_level = 16'd2048;
		gbl_stamp = '0;
		clear_table();
		addr_pool[0] = 32'h0;
		addr_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 16; i++)
			addr_pool[i] = $urandom;
		cfg_set[0] = '{16'd32, 16'd50, 16'd4, 16'd500};
		cfg_set[1] = '{16'd1, 16'd0, 16'd1, 16'd0};
		cfg_set[2] = '{16'd1023, 16'd65535, 16'd1023, 16'd65535};
		cfg_set[3] = '{16'hFFFF, 16'd1, 16'd1, 16'd1};
		cfg_set[4] = '{16'hFC00, 16'd50, 16'd4, 16'd500};
		cfg_set[5] = '{16'd3, 16'd20, 16'd2, 16'd100};
		cfg_set[6] = '{16'($urandom_range(1, 1023)), 16'($urandom_range(0, 200)),
			16'($urandom_range(1, 8)), 16'($urandom_range(0, 800))};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[k]) begin
			send_beat(dir_tab[k].cmd, dir_tab[k].a, dir_tab[k].t,
				dir_tab[k].known, dir_tab[k].res);
			sender_gap();
		end
		clock_ms = 48'd1000;

		for (int p = 1; p < PhaseCount; p++) begin
			drain(400);
			for (int r = 0; r < 4; r++)
				write_reg(2'(r), cfg_set[p][r]);
			if (p == PhaseCount - 1)
				quiet = 1'b1;
			for (int n = 0; n < PhaseBeats; n++) begin
				if (p == 2 && n == 100)
					drain(0);
				random_beat();
				sender_gap();
			end
		end

		drain(400);
		if (mismatches == 0 && verdicts_due.size() == 0)
			$display("dual_token_bucket_limiter_tb: done, clean");
		else
			$display("dual_token_bucket_limiter_tb: done, errors");
		$finish;
	end
endmodule
